/* hw/rtl/sprbb_pkg.sv */
// Shared constants, types and helper functions for the sprite bounding box pipeline.
package sprbb_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int ANGLE_BITS = 16;
  localparam int TRIG_BITS  = 14;

  localparam int COORD_W = 24;
  localparam int SCALE_W = 16;
  localparam int SIZE_W  = 23;
  localparam int TRIG_W  = TRIG_BITS + 2;
  // corner offset from pivot: size minus pivot needs one more bit than a coordinate; two are given
  localparam int DIFF_W  = COORD_W + 2;
  localparam int TX_W    = DIFF_W + SCALE_W;
  localparam int PROD_W  = TX_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 4;
  localparam int RND_SH  = FRAC_BITS + TRIG_BITS;

  // pipeline latencies
  localparam int TRIG_LAT = 6;
  localparam int PIPE_LAT = 1 + TRIG_LAT + 2 + 2;

  // Q30 coefficients of the odd quarter-wave sine polynomial
  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598668;
  localparam logic [31:0] C5 = 32'd85569306;
  localparam logic [31:0] C7 = 32'd5026995;
  localparam logic [31:0] C9 = 32'd172272;

  localparam logic [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1 << TRIG_BITS);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [TX_W-1:0]    tx_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

  // scaled corner offsets and position traveling with the sine/cosine
  typedef struct packed {
    tx_t    tx0;
    tx_t    tx1;
    tx_t    ty0;
    tx_t    ty1;
    coord_t px;
    coord_t py;
  } geom_t;

  // phase within the quarter, mirrored in odd quadrants
  function automatic logic [16:0] phase_z(input logic [31:0] a);
    logic [16:0] f;
    f = {1'b0, a[29:14]};
    return a[30] ? (17'h10000 - f) : f;
  endfunction

  // round half up to FRAC_BITS fraction bits, then saturate
  function automatic coord_t round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = (v + (SUM_W'(1) <<< (RND_SH - 1))) >>> RND_SH;
    if (t > SUM_W'((1 << (COORD_W - 1)) - 1))
      return coord_t'((1 << (COORD_W - 1)) - 1);
    else if (t < -SUM_W'(1 << (COORD_W - 1)))
      return coord_t'(-(1 << (COORD_W - 1)));
    else
      return t[COORD_W-1:0];
  endfunction

endpackage

/* hw/rtl/sprbb_trig.sv */
// Six-stage polynomial sine unit for one quarter-wave phase with sign.
module sprbb_trig (
  input  logic                 clk,
  input  logic [16:0]          z,
  input  logic                 neg,
  output sprbb_pkg::trig_t     val
);
  import sprbb_pkg::*;

  logic [16:0] zr  [1:5];
  logic        nr  [1:5];
  logic [16:0] z2r [1:4];
  logic [31:0] pr  [2:5];
  logic [48:0] fin;
  logic [16:0] mag;

  // stage 1: square of the phase
  always_ff @(posedge clk) begin
    zr[1]  <= z;
    nr[1]  <= neg;
    z2r[1] <= 17'((34'(z) * 34'(z)) >> 16);
  end

  // stages 2..5: Horner steps, each product floored by 16 bits
  always_ff @(posedge clk) begin
    pr[2] <= C7 - 32'((48'(C9)    * 48'(z2r[1])) >> 16);
    pr[3] <= C5 - 32'((48'(pr[2]) * 48'(z2r[2])) >> 16);
    pr[4] <= C3 - 32'((48'(pr[3]) * 48'(z2r[3])) >> 16);
    pr[5] <= C1 - 32'((48'(pr[4]) * 48'(z2r[4])) >> 16);
    for (int i = 2; i <= 5; i++) begin
      zr[i] <= zr[i-1];
      nr[i] <= nr[i-1];
    end
    for (int i = 2; i <= 4; i++) begin
      z2r[i] <= z2r[i-1];
    end
  end

  // stage 6: last multiply, round to Q14, clamp, apply sign
  assign fin = 49'(pr[5]) * 49'(zr[5]) + (49'(1) << 31);
  assign mag = 17'(fin >> 32);

  always_ff @(posedge clk) begin
    if (mag > 17'(TRIG_ONE))
      val <= nr[5] ? -trig_t'(TRIG_ONE) : trig_t'(TRIG_ONE);
    else
      val <= nr[5] ? -trig_t'(mag) : trig_t'(mag);
  end

endmodule

/* hw/rtl/sprbb_corner.sv */
// Two-stage corner rotation: products, then sum with position, round and saturate.
module sprbb_corner (
  input  logic                   clk,
  input  sprbb_pkg::geom_t       geom,
  input  sprbb_pkg::trig_t       sin_v,
  input  sprbb_pkg::trig_t       cos_v,
  output sprbb_pkg::coord_t      cx [4],
  output sprbb_pkg::coord_t      cy [4]
);
  import sprbb_pkg::*;

  logic signed [PROD_W-1:0] xc [2];
  logic signed [PROD_W-1:0] xs [2];
  logic signed [PROD_W-1:0] yc [2];
  logic signed [PROD_W-1:0] ys [2];
  coord_t px;
  coord_t py;

  // stage A: eight rotation products
  always_ff @(posedge clk) begin
    xc[0] <= PROD_W'(geom.tx0) * PROD_W'(cos_v);
    xc[1] <= PROD_W'(geom.tx1) * PROD_W'(cos_v);
    xs[0] <= PROD_W'(geom.tx0) * PROD_W'(sin_v);
    xs[1] <= PROD_W'(geom.tx1) * PROD_W'(sin_v);
    yc[0] <= PROD_W'(geom.ty0) * PROD_W'(cos_v);
    yc[1] <= PROD_W'(geom.ty1) * PROD_W'(cos_v);
    ys[0] <= PROD_W'(geom.ty0) * PROD_W'(sin_v);
    ys[1] <= PROD_W'(geom.ty1) * PROD_W'(sin_v);
    px    <= geom.px;
    py    <= geom.py;
  end

  // stage B: corners (0,0) (w,0) (w,h) (0,h)
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      logic ix;
      logic iy;
      ix = (k == 1) || (k == 2);
      iy = (k >= 2);
      cx[k] <= round_sat(SUM_W'(xc[ix]) - SUM_W'(ys[iy]) + (SUM_W'(px) <<< RND_SH));
      cy[k] <= round_sat(SUM_W'(xs[ix]) + SUM_W'(yc[iy]) + (SUM_W'(py) <<< RND_SH));
    end
  end

endmodule

/* hw/rtl/sprbb_minmax.sv */
// Two-stage min/max tree over the four corners.
module sprbb_minmax (
  input  logic               clk,
  input  sprbb_pkg::coord_t  cx [4],
  input  sprbb_pkg::coord_t  cy [4],
  output sprbb_pkg::coord_t  min_x,
  output sprbb_pkg::coord_t  min_y,
  output sprbb_pkg::coord_t  max_x,
  output sprbb_pkg::coord_t  max_y
);
  import sprbb_pkg::*;

  coord_t lx [2];
  coord_t hx [2];
  coord_t ly [2];
  coord_t hy [2];

  // first level: pairs
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      lx[i] <= (cx[2*i] < cx[2*i+1]) ? cx[2*i] : cx[2*i+1];
      hx[i] <= (cx[2*i] > cx[2*i+1]) ? cx[2*i] : cx[2*i+1];
      ly[i] <= (cy[2*i] < cy[2*i+1]) ? cy[2*i] : cy[2*i+1];
      hy[i] <= (cy[2*i] > cy[2*i+1]) ? cy[2*i] : cy[2*i+1];
    end
  end

  // second level: result registers
  always_ff @(posedge clk) begin
    min_x <= (lx[0] < lx[1]) ? lx[0] : lx[1];
    max_x <= (hx[0] > hx[1]) ? hx[0] : hx[1];
    min_y <= (ly[0] < ly[1]) ? ly[0] : ly[1];
    max_y <= (hy[0] > hy[1]) ? hy[0] : hy[1];
  end

endmodule

/* hw/rtl/sprite_rotated_bounding_box.sv */
// Top level: bounding box of a scaled, rotated sprite, fully pipelined.
// One sprite is taken every cycle (busy never rises); its box appears on the
// result ports with done high once the start transfer has passed the stages:
// one input stage forming the scaled corner offsets, six stages of the
// sine/cosine polynomial unit, two of corner rotation and rounding, and two of
// the min/max tree. Results are shown for one cycle and cannot be held off.
module sprite_rotated_bounding_box (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [23:0]           pos_x,
  input  logic signed [23:0]           pos_y,
  input  logic signed [23:0]           pivot_x,
  input  logic signed [23:0]           pivot_y,
  input  logic signed [15:0]           scale_x,
  input  logic signed [15:0]           scale_y,
  input  logic [15:0]                  angle,
  input  logic [22:0]                  size_w,
  input  logic [22:0]                  size_h,
  output logic                         done,
  output logic signed [23:0]           min_x,
  output logic signed [23:0]           min_y,
  output logic signed [23:0]           max_x,
  output logic signed [23:0]           max_y
);
  import sprbb_pkg::*;

  logic [PIPE_LAT:1] vld;
  geom_t       geom1;
  geom_t       gdly [1:TRIG_LAT];
  logic [31:0] a_s;
  logic [31:0] a_c;
  logic [16:0] z_s;
  logic [16:0] z_c;
  logic        n_s;
  logic        n_c;
  trig_t       sin_v;
  trig_t       cos_v;
  coord_t      cx [4];
  coord_t      cy [4];

  assign busy = 1'b0;
  assign done = vld[PIPE_LAT];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-1:1], start};
    end
  end

  // turn angle aligned to 32 bits; cosine is a quarter turn ahead
  assign a_s = {angle[ANGLE_BITS-1:0], {(32 - ANGLE_BITS){1'b0}}};
  assign a_c = a_s + 32'h4000_0000;

  // stage 1: scaled corner offsets and phases
  always_ff @(posedge clk) begin
    geom1.tx0 <= TX_W'(DIFF_W'(0) - DIFF_W'(pivot_x)) * TX_W'(scale_x);
    geom1.ty0 <= TX_W'(DIFF_W'(0) - DIFF_W'(pivot_y)) * TX_W'(scale_y);
    geom1.tx1 <= TX_W'(DIFF_W'($signed({1'b0, size_w})) - DIFF_W'(pivot_x))
                 * TX_W'(scale_x);
    geom1.ty1 <= TX_W'(DIFF_W'($signed({1'b0, size_h})) - DIFF_W'(pivot_y))
                 * TX_W'(scale_y);
    geom1.px  <= pos_x;
    geom1.py  <= pos_y;
    z_s       <= phase_z(a_s);
    z_c       <= phase_z(a_c);
    n_s       <= a_s[31];
    n_c       <= a_c[31];
  end

  // geometry waits for the trig unit
  always_ff @(posedge clk) begin
    gdly[1] <= geom1;
    for (int i = 2; i <= TRIG_LAT; i++) begin
      gdly[i] <= gdly[i-1];
    end
  end

  sprbb_trig u_sin (.clk(clk), .z(z_s), .neg(n_s), .val(sin_v));
  sprbb_trig u_cos (.clk(clk), .z(z_c), .neg(n_c), .val(cos_v));

  sprbb_corner u_corner (
    .clk(clk), .geom(gdly[TRIG_LAT]), .sin_v(sin_v), .cos_v(cos_v),
    .cx(cx), .cy(cy)
  );

  sprbb_minmax u_minmax (
    .clk(clk), .cx(cx), .cy(cy),
    .min_x(min_x), .min_y(min_y), .max_x(max_x), .max_y(max_y)
  );

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##11 done) else $error("result not delivered after pipeline latency");
  a_order_x: assert property (@(posedge clk) disable iff (rst)
    done |-> (min_x <= max_x)) else $error("min_x above max_x");
  a_order_y: assert property (@(posedge clk) disable iff (rst)
    done |-> (min_y <= max_y)) else $error("min_y above max_y");
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[PIPE_LAT-1])) else $error("result without a transfer");
`endif

endmodule
